[design/abps_pkg.sv]
// ----------------------------------------------------------------------------
// abps_pkg
// Shared types and constants of the alarm beep pattern sequencer.
// ----------------------------------------------------------------------------
package abps_pkg;

    localparam int PENDING_DEPTH_DEF = 4;
    localparam int TIME_WIDTH_DEF    = 16;

    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int IN_W      = 8;
    localparam int OUT_W     = 40;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_START   = 3'd1,
        CMD_STOP    = 3'd2,
        CMD_EMPTY   = 3'd3,
        CMD_DISABLE = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ACC_NONE     = 3'd0,
        ACC_CRASH    = 3'd1,
        ACC_FALL     = 3'd2,
        ACC_SUDDEN   = 3'd3,
        ACC_COMBINED = 3'd4
    } t_acc;

    localparam int REG_CRASH_ON     = 0;
    localparam int REG_CRASH_OFF    = 1;
    localparam int REG_FALL_ON      = 2;
    localparam int REG_FALL_OFF     = 3;
    localparam int REG_SUDDEN_ON    = 4;
    localparam int REG_SUDDEN_OFF   = 5;
    localparam int REG_COMBINED_ON  = 6;
    localparam int REG_COMBINED_OFF = 7;

    typedef logic [NUM_REGS-1:0][CFG_W-1:0] t_cfg_regs;

    localparam t_cfg_regs CFG_RESET = {
        16'd100, 16'd100, 16'd200, 16'd300, 16'd300, 16'd500, 16'd100, 16'd200
    };

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [1:0] cmd;
        logic [2:0] acc;
    } t_fifo_ctl;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] head_cmd;
        logic [2:0] head_acc;
    } t_fifo_stat;

    typedef struct packed {
        logic        buzzer_on;
        logic        alerting;
        logic [15:0] alert_count;
        logic [15:0] processed_count;
        logic        dropped;
    } t_seq_res;

    typedef struct packed {
        logic [1:0]  pad;
        logic        dropped;
        logic [2:0]  pending_count;
        logic [15:0] processed_count;
        logic [15:0] alert_count;
        logic        alerting;
        logic        buzzer_on;
    } t_result;

endpackage

[design/abps_ram.sv]
// ----------------------------------------------------------------------------
// abps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module abps_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/abps_fifo.sv]
// ----------------------------------------------------------------------------
// abps_fifo
// Pending command queue: show-ahead FIFO over a RAM with write bypass.
// ----------------------------------------------------------------------------
module abps_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  abps_pkg::t_fifo_ctl            i_ctl,
    output abps_pkg::t_fifo_stat           o_stat,
    output logic [$clog2(DEPTH+1)-1:0]     o_fill_next
);
    import abps_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int EW = 5;

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_byp;
    logic [EW-1:0] r_byp_data;
    logic [EW-1:0] w_wdata;
    logic [EW-1:0] w_rdata;
    logic [EW-1:0] w_head;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        if (p == AW'(DEPTH - 1)) begin
            return '0;
        end
        return p + AW'(1);
    endfunction

    assign w_wdata = {i_ctl.cmd, i_ctl.acc};
    assign n_head  = i_ctl.pop  ? ptr_inc(r_head) : r_head;
    assign n_tail  = i_ctl.push ? ptr_inc(r_tail) : r_tail;

    always_comb begin
        n_fill = r_fill;
        if (i_ctl.push && !i_ctl.pop) begin
            n_fill = r_fill + FW'(1);
        end else if (i_ctl.pop && !i_ctl.push) begin
            n_fill = r_fill - FW'(1);
        end
    end

    abps_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.push),
        .i_waddr (r_tail),
        .i_wdata (w_wdata),
        .i_raddr (n_head),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
            r_byp  <= 1'b0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
            r_byp  <= i_ctl.push && (r_tail == n_head);
        end
        r_byp_data <= w_wdata;
    end

    assign w_head          = r_byp ? r_byp_data : w_rdata;
    assign o_stat.full     = (r_fill == FW'(DEPTH));
    assign o_stat.empty    = (r_fill == '0);
    assign o_stat.head_cmd = w_head[4:3];
    assign o_stat.head_acc = w_head[2:0];
    assign o_fill_next     = n_fill;

endmodule

[design/abps_seq.sv]
// ----------------------------------------------------------------------------
// abps_seq
// Alarm state, phase timer and counters; decides each command in one pass.
// ----------------------------------------------------------------------------
module abps_seq #(
    parameter int TIME_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [2:0]            i_cmd,
    input  logic [2:0]            i_acc,
    input  abps_pkg::t_cfg_regs   i_cfg,
    input  abps_pkg::t_fifo_stat  i_fifo,
    output abps_pkg::t_fifo_ctl   o_fifo_ctl,
    output abps_pkg::t_seq_res    o_res
);
    import abps_pkg::*;

    localparam logic [32:0] TIME_MAX = (33'd1 << TIME_WIDTH) - 33'd1;

    logic                  r_active, n_active;
    logic                  r_off, n_off;
    logic [TIME_WIDTH-1:0] r_elapsed, n_elapsed;
    logic [TIME_WIDTH-1:0] r_on_len, n_on_len;
    logic [TIME_WIDTH-1:0] r_off_len, n_off_len;
    logic [15:0]           r_alert, n_alert;
    logic [15:0]           r_processed, n_processed;

    logic [2:0]            w_ld_acc;
    logic [15:0]           w_ld_on16, w_ld_off16;
    logic [TIME_WIDTH-1:0] w_ld_on, w_ld_off;
    logic [TIME_WIDTH-1:0] w_el_inc, w_len;
    logic                  w_push, w_pop, w_dropped, w_act_idle;
    logic [1:0]            w_act_cmd;

    function automatic logic [TIME_WIDTH-1:0] clamp_time(input logic [15:0] v);
        if ({17'd0, v} > TIME_MAX) begin
            return '1;
        end
        return TIME_WIDTH'(v);
    endfunction

    assign w_ld_acc = (i_cmd == CMD_TICK) ? i_fifo.head_acc : i_acc;

    always_comb begin
        unique case (w_ld_acc)
            ACC_CRASH: begin
                w_ld_on16  = i_cfg[REG_CRASH_ON];
                w_ld_off16 = i_cfg[REG_CRASH_OFF];
            end
            ACC_FALL: begin
                w_ld_on16  = i_cfg[REG_FALL_ON];
                w_ld_off16 = i_cfg[REG_FALL_OFF];
            end
            ACC_COMBINED: begin
                w_ld_on16  = i_cfg[REG_COMBINED_ON];
                w_ld_off16 = i_cfg[REG_COMBINED_OFF];
            end
            default: begin
                w_ld_on16  = i_cfg[REG_SUDDEN_ON];
                w_ld_off16 = i_cfg[REG_SUDDEN_OFF];
            end
        endcase
    end

    assign w_ld_on  = clamp_time(w_ld_on16);
    assign w_ld_off = clamp_time(w_ld_off16);
    assign w_el_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + TIME_WIDTH'(1);
    assign w_len    = r_off ? r_off_len : r_on_len;

    always_comb begin
        n_active    = r_active;
        n_off       = r_off;
        n_elapsed   = r_elapsed;
        n_on_len    = r_on_len;
        n_off_len   = r_off_len;
        n_alert     = r_alert;
        n_processed = r_processed;
        w_push      = 1'b0;
        w_pop       = 1'b0;
        w_dropped   = 1'b0;
        w_act_idle  = 1'b0;
        w_act_cmd   = i_cmd[1:0];
        unique case (i_cmd)
            CMD_TICK: begin
                if (!r_active) begin
                    if (!i_fifo.empty) begin
                        w_pop      = 1'b1;
                        w_act_idle = 1'b1;
                        w_act_cmd  = i_fifo.head_cmd;
                    end
                end else if (w_el_inc < w_len) begin
                    n_elapsed = w_el_inc;
                end else begin
                    n_elapsed = '0;
                    if (!r_off) begin
                        n_off = 1'b1;
                    end else begin
                        n_off = 1'b0;
                        if (!i_fifo.empty) begin
                            w_pop       = 1'b1;
                            n_processed = r_processed + 16'd1;
                            if (i_fifo.head_cmd == 2'(CMD_STOP)) begin
                                n_active = 1'b0;
                            end else if (i_fifo.head_cmd == 2'(CMD_START)) begin
                                n_alert   = r_alert + 16'd1;
                                n_on_len  = w_ld_on;
                                n_off_len = w_ld_off;
                            end
                        end
                    end
                end
            end
            CMD_START, CMD_STOP, CMD_EMPTY: begin
                if (!r_active && i_fifo.empty) begin
                    w_act_idle = 1'b1;
                end else if (!i_fifo.full) begin
                    w_push = 1'b1;
                end else begin
                    w_dropped = 1'b1;
                end
            end
            CMD_DISABLE: begin
                n_active  = 1'b0;
                n_off     = 1'b0;
                n_elapsed = '0;
            end
            default: begin
            end
        endcase
        if (w_act_idle) begin
            n_processed = r_processed + 16'd1;
            if (w_act_cmd == 2'(CMD_START)) begin
                n_active  = 1'b1;
                n_off     = 1'b0;
                n_elapsed = '0;
                n_alert   = r_alert + 16'd1;
                n_on_len  = w_ld_on;
                n_off_len = w_ld_off;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_off       <= 1'b0;
            r_elapsed   <= '0;
            r_on_len    <= '0;
            r_off_len   <= '0;
            r_alert     <= '0;
            r_processed <= '0;
        end else if (i_step) begin
            r_active    <= n_active;
            r_off       <= n_off;
            r_elapsed   <= n_elapsed;
            r_on_len    <= n_on_len;
            r_off_len   <= n_off_len;
            r_alert     <= n_alert;
            r_processed <= n_processed;
        end
    end

    assign o_fifo_ctl.push = w_push && i_step;
    assign o_fifo_ctl.pop  = w_pop && i_step;
    assign o_fifo_ctl.cmd  = i_cmd[1:0];
    assign o_fifo_ctl.acc  = i_acc;

    assign o_res.buzzer_on       = n_active && !n_off;
    assign o_res.alerting        = n_active;
    assign o_res.alert_count     = n_alert;
    assign o_res.processed_count = n_processed;
    assign o_res.dropped         = w_dropped;

endmodule

[design/alarm_beep_pattern_sequencer.sv]
// ----------------------------------------------------------------------------
// alarm_beep_pattern_sequencer
// Buzzer alarm sequencer: beep patterns by accident type, pending command
// queue, alert and processed counters. One result per command.
//
//   channel  | dir | transfer when                  | contents
//   s_axis   | in  | s_axis_tvalid & s_axis_tready  | one tick or command
//   m_axis   | out | m_axis_tvalid & m_axis_tready  | status after that item
//   cfg      | in  | i_cfg_wr_en                    | one pattern length reg
//
// Items go through the input register and sequencer into the result register;
// a new item is taken every cycle unless the output stalls. The input and result
// registers hold across output stalls, so one item is still taken while a result
// waits. Synchronous active-low reset clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
module alarm_beep_pattern_sequencer #(
    parameter int PENDING_DEPTH = abps_pkg::PENDING_DEPTH_DEF,
    parameter int TIME_WIDTH    = abps_pkg::TIME_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [2:0] command, [5:3] accident_type, [7:6] zero
    input  logic [abps_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] buzzer_on, [1] alerting, [17:2] alert_count, [33:18] processed_count,
    // [36:34] pending_count, [37] dropped, [39:38] zero
    output logic [abps_pkg::OUT_W-1:0]    m_axis_tdata,
    input  logic                          i_cfg_wr_en,
    input  logic [abps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [abps_pkg::CFG_W-1:0]    i_cfg_data
);
    import abps_pkg::*;

    localparam int FW = $clog2(PENDING_DEPTH + 1);

    t_cfg_regs  r_cfg;
    logic       r_in_valid;
    logic [2:0] r_in_cmd;
    logic [2:0] r_in_acc;
    logic       r_out_valid;
    t_result    r_out;
    logic       w_adv;
    t_fifo_ctl  w_fifo_ctl;
    t_fifo_stat w_fifo_stat;
    t_seq_res   w_res;
    logic [FW-1:0] w_fill_next;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd <= s_axis_tdata[2:0];
            r_in_acc <= s_axis_tdata[5:3];
        end
    end

    abps_fifo #(
        .DEPTH (PENDING_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_fifo_ctl),
        .o_stat      (w_fifo_stat),
        .o_fill_next (w_fill_next)
    );

    abps_seq #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_adv),
        .i_cmd      (r_in_cmd),
        .i_acc      (r_in_acc),
        .i_cfg      (r_cfg),
        .i_fifo     (w_fifo_stat),
        .o_fifo_ctl (w_fifo_ctl),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else if (w_adv) begin
            r_out_valid           <= 1'b1;
            r_out.pad             <= '0;
            r_out.dropped         <= w_res.dropped;
            r_out.pending_count   <= 3'(w_fill_next);
            r_out.processed_count <= w_res.processed_count;
            r_out.alert_count     <= w_res.alert_count;
            r_out.alerting        <= w_res.alerting;
            r_out.buzzer_on       <= w_res.buzzer_on;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

`ifndef SYNTHESIS
    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.dropped |-> r_out.pending_count == 3'(PENDING_DEPTH))
        else $error("dropped command while queue not full");

    a_buzz_needs_alert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.buzzer_on |-> r_out.alerting)
        else $error("buzzer on without running alarm");

    a_processed_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (16'(r_out.processed_count - $past(r_out.processed_count)) == 16'd0 ||
                   16'(r_out.processed_count - $past(r_out.processed_count)) == 16'd1))
        else $error("processed count moved by more than one");

    a_alert_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (16'(r_out.alert_count - $past(r_out.alert_count)) == 16'd0 ||
                   16'(r_out.alert_count - $past(r_out.alert_count)) == 16'd1))
        else $error("alert count moved by more than one");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_out_valid && !m_axis_tready)
        else $error("input stalled without a full pipeline");
`endif

endmodule
